/* src/tmtw_pkg.sv */
// Shared constants, codes and types for the text mode terminal writer.
`timescale 1ns / 1ps

package tmtw_pkg;

   // Screen geometry.
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = ROWS * COLUMNS;

   // Cell buffer addressing and sweep counter widths.
   localparam int ADDR_W = $clog2(CELL_COUNT);
   localparam int CNT_W  = $clog2(CELL_COUNT + 1);

   // Internal cursor widths.
   localparam int ROW_W = $clog2(ROWS);
   localparam int COL_W = $clog2(COLUMNS);

   // Field widths of the request and response words.
   localparam int CHAR_W      = 8;
   localparam int ATTR_W      = 8;
   localparam int CELL_W      = CHAR_W + ATTR_W;
   localparam int INDEX_W     = 11;
   localparam int OUT_ROW_W   = 5;
   localparam int OUT_COL_W   = 7;

   // Character and cell constants.
   localparam logic [CHAR_W-1:0] NEWLINE_CHAR     = 8'd10;
   localparam logic [CHAR_W-1:0] SPACE_CHAR       = 8'd32;
   localparam logic [CELL_W-1:0] BLANK_CELL       = 16'h0720;
   localparam logic [ATTR_W-1:0] TEXT_COLOR_RESET = 8'd7;

   // Register file port.
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = CSR_ADDR_W - 2;
   localparam logic [CSR_INDEX_W-1:0] REG_TEXT_COLOR = 1'b0;

   // Operation codes.
   typedef enum logic {
      OP_PUT  = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef logic [CELL_W-1:0] cell_type;

endpackage

/* src/tmtw_if.sv */
// Request and response channel interfaces of the text mode terminal writer.
`timescale 1ns / 1ps

interface tmtw_req_if import tmtw_pkg::*; ();
   logic               valid;
   logic               ready;
   op_type             op;
   logic [CHAR_W-1:0]  ch;
   logic [INDEX_W-1:0] cell_index;

   modport source (output valid, output op, output ch, output cell_index, input ready);
   modport sink   (input valid, input op, input ch, input cell_index, output ready);
endinterface

interface tmtw_rsp_if import tmtw_pkg::*; ();
   logic                 valid;
   logic                 ready;
   cell_type             cell_entry;
   logic [OUT_ROW_W-1:0] cursor_row;
   logic [OUT_COL_W-1:0] cursor_column;

   modport source (output valid, output cell_entry, output cursor_row,
                   output cursor_column, input ready);
   modport sink   (input valid, input cell_entry, input cursor_row,
                   input cursor_column, output ready);
endinterface

/* src/text_mode_terminal_writer.sv */
// Text mode terminal writer: cell buffer in RAM, cursor, scroll and clear sequencer.
// A non-scrolling put answers in the cycle after acceptance; a read holds in ST_READ.
// A put that scrolls holds the block while rows 1 to ROWS-1 are copied one row up,
// one cell a cycle via the single RAM read port; ST_BLANK then blanks the last row.
// Throughput: one put per cycle while responses drain and no put scrolls.
// Reset: synchronous; afterwards a clearing pass writes grey-on-black spaces
// to all CELL_COUNT cells before the first request is taken.
`timescale 1ns / 1ps

module text_mode_terminal_writer import tmtw_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tmtw_req_if.sink              req_if,
   tmtw_rsp_if.source            rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_BLANK
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 copy_valid_ff, copy_valid_in;
   logic [ADDR_W-1:0]    copy_addr_ff, copy_addr_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ATTR_W-1:0]    color_ff, color_in;
   logic                 rd_hit_ff, rd_hit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   cell_type             rsp_entry_ff, rsp_entry_in;
   logic [OUT_ROW_W-1:0] rsp_row_ff, rsp_row_in;
   logic [OUT_COL_W-1:0] rsp_col_ff, rsp_col_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   cell_type          ram_wdata;
   logic [ADDR_W-1:0] ram_raddr;
   cell_type          ram_rdata;

   logic                   req_accept;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic                   put_newline;
   logic                   put_wrap;
   logic                   put_scroll;
   logic [ROW_W-1:0]       put_row;
   logic [COL_W-1:0]       put_col;
   logic [ADDR_W-1:0]      put_addr;

   // Cell buffer.
   tmtw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_cells (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Register port: always ready, one register.
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_index == REG_TEXT_COLOR) ? CSR_DATA_W'(color_ff) : '0;

   // A new word is taken when idle and the response slot is free by the next edge.
   assign req_if.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign req_accept   = req_if.valid && req_if.ready;

   // Cursor arithmetic for a put.
   assign put_newline = (req_if.ch == NEWLINE_CHAR);
   assign put_wrap    = put_newline || (col_ff == COL_W'(COLUMNS - 1));
   assign put_scroll  = put_wrap && (row_ff == ROW_W'(ROWS - 1));
   assign put_col     = put_wrap ? '0 : col_ff + 1'b1;
   assign put_row     = (put_wrap && !put_scroll) ? row_ff + 1'b1 : row_ff;
   assign put_addr    = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff);

   // Next-state logic and RAM port control.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      copy_valid_in = copy_valid_ff;
      copy_addr_in  = copy_addr_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      color_in      = color_ff;
      rd_hit_in     = rd_hit_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      ram_we        = 1'b0;
      ram_waddr     = copy_addr_ff;
      ram_wdata     = ram_rdata;
      ram_raddr     = ADDR_W'(cnt_ff);

      // The response word leaves when the sink takes it.
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write && (csr_index == REG_TEXT_COLOR)) begin
         color_in = csr_pwdata[ATTR_W-1:0];
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(cnt_ff);
            ram_wdata = BLANK_CELL;
            if (cnt_ff == CNT_W'(CELL_COUNT - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            ram_raddr = ADDR_W'(req_if.cell_index);
            if (req_accept) begin
               if (req_if.op == OP_READ) begin
                  rd_hit_in = (32'(req_if.cell_index) < 32'(CELL_COUNT));
                  state_in  = ST_READ;
               end else begin
                  // Store the character unless it is a newline.
                  if (!put_newline) begin
                     ram_we    = 1'b1;
                     ram_waddr = put_addr;
                     ram_wdata = {color_ff, req_if.ch};
                  end
                  row_in = put_row;
                  col_in = put_col;
                  if (put_scroll) begin
                     cnt_in        = CNT_W'(COLUMNS);
                     copy_valid_in = 1'b0;
                     state_in      = ST_SCROLL;
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_entry_in = '0;
                     rsp_row_in   = OUT_ROW_W'(put_row);
                     rsp_col_in   = OUT_COL_W'(put_col);
                  end
               end
            end
         end

         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_entry_in = rd_hit_ff ? ram_rdata : '0;
            rsp_row_in   = OUT_ROW_W'(row_ff);
            rsp_col_in   = OUT_COL_W'(col_ff);
            state_in     = ST_IDLE;
         end

         ST_SCROLL: begin
            // Read one row ahead, write the cell fetched last cycle one row up.
            ram_we    = copy_valid_ff;
            ram_waddr = copy_addr_ff;
            ram_wdata = ram_rdata;
            if (cnt_ff != CNT_W'(CELL_COUNT)) begin
               ram_raddr     = ADDR_W'(cnt_ff);
               copy_valid_in = 1'b1;
               copy_addr_in  = ADDR_W'(cnt_ff - CNT_W'(COLUMNS));
               cnt_in        = cnt_ff + 1'b1;
            end else begin
               copy_valid_in = 1'b0;
               cnt_in        = CNT_W'((ROWS - 1) * COLUMNS);
               state_in      = ST_BLANK;
            end
         end

         ST_BLANK: begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(cnt_ff);
            ram_wdata = {color_ff, SPACE_CHAR};
            if (cnt_ff == CNT_W'(CELL_COUNT - 1)) begin
               cnt_in       = '0;
               rsp_valid_in = 1'b1;
               rsp_entry_in = '0;
               rsp_row_in   = OUT_ROW_W'(row_ff);
               rsp_col_in   = OUT_COL_W'(col_ff);
               state_in     = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      copy_addr_ff <= copy_addr_in;
      rd_hit_ff    <= rd_hit_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cnt_ff        <= '0;
         copy_valid_ff <= 1'b0;
         row_ff        <= '0;
         col_ff        <= '0;
         color_ff      <= TEXT_COLOR_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         copy_valid_ff <= copy_valid_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         color_ff      <= color_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.cell_entry    = rsp_entry_ff;
   assign rsp_if.cursor_row    = rsp_row_ff;
   assign rsp_if.cursor_column = rsp_col_ff;

endmodule

/* src/tmtw_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module tmtw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // A read of the address being written in the same cycle returns the old contents.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* src/tmtw_checker.sv */
// Port-level checker for the text mode terminal writer and its bind.
`timescale 1ns / 1ps

module tmtw_checker import tmtw_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input cell_type             rsp_cell_entry,
   input logic [OUT_ROW_W-1:0] rsp_cursor_row,
   input logic [OUT_COL_W-1:0] rsp_cursor_column
);

   // Reset leaves the block busy clearing, with no word pending.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("block not quiet after reset");

   // An accepted word is either answered next cycle or keeps the block busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (rsp_valid || !req_ready))
      else $error("accepted word neither answered nor holding the block");

   // The reported cursor lies on the screen.
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_cursor_row) < ROWS) && (32'(rsp_cursor_column) < COLUMNS))
      else $error("cursor off screen");

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_cell_entry)
         && $stable(rsp_cursor_row) && $stable(rsp_cursor_column))
      else $error("stalled response changed");

endmodule

bind text_mode_terminal_writer tmtw_checker u_tmtw_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_if.valid),
   .req_ready         (req_if.ready),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_cell_entry    (rsp_if.cell_entry),
   .rsp_cursor_row    (rsp_if.cursor_row),
   .rsp_cursor_column (rsp_if.cursor_column)
);

/* tb/sv/text_mode_terminal_writer_test.sv */
// Self-checking testbench for the text mode terminal writer: cursor, wrap, scroll and cell reads.
`timescale 1ns / 1ps

module text_mode_terminal_writer_test;
   import tmtw_pkg::*;

   // Run control constants.
   localparam int PHASE_COUNT     = 8;
   localparam int PHASE_REQUESTS  = 250;
   localparam int IDLE_PERCENT    = 38;
   localparam int STEADY_PHASE    = 3;
   localparam int SETTLE_CYCLES   = CELL_COUNT + 100;
   localparam int DRAIN_CYCLES    = 20;
   localparam int WATCHDOG_LIMIT  = 20000;
   localparam int PRINT_LIMIT     = 200;

   // Register byte addresses.
   localparam logic [CSR_ADDR_W-1:0] ADDR_TEXT_COLOR = CSR_ADDR_W'(4 * REG_TEXT_COLOR);
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED   = CSR_ADDR_W'(4);

   // One request word as queued for the driver.
   typedef struct {
      op_type              op;
      logic [CHAR_W-1:0]   ch;
      logic [INDEX_W-1:0]  cell_index;
      bit                  drain_first;
   } term_request_type;

   // One response word as predicted.
   typedef struct {
      cell_type             cell_entry;
      logic [OUT_ROW_W-1:0] cursor_row;
      logic [OUT_COL_W-1:0] cursor_column;
   } term_word_type;

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   tmtw_req_if req_bus ();
   tmtw_rsp_if rsp_bus ();

   text_mode_terminal_writer u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Shared testbench state.
   term_request_type pending_requests[$];
   term_word_type    expected_words[$];
   term_request_type current_request;
   int               fail_count = 0;
   int               stall_cycles = 0;
   bit               steady = 1'b0;

   // Shadow copy of the screen, the cursor and the attribute register.
   cell_type          screen_shadow [CELL_COUNT];
   int                shadow_row;
   int                shadow_column;
   logic [ATTR_W-1:0] shadow_color;

   // Clock generation.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(string what, longint want, longint got);
      fail_count++;
      if (fail_count <= PRINT_LIMIT)
         $display("MISMATCH %s: expected 0x%0h, got 0x%0h", what, want, got);
   endtask

   function automatic bit idle_now();
      return !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
   endfunction

   // Moving past the last row shifts every row up and blanks the bottom one.
   function automatic void scroll_shadow();
      for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
         screen_shadow[i] = screen_shadow[i + COLUMNS];
      for (int i = 0; i < COLUMNS; i++)
         screen_shadow[(ROWS - 1) * COLUMNS + i] = {shadow_color, SPACE_CHAR};
   endfunction

   // Applies one request to the shadow screen and returns the word it must produce.
   function automatic term_word_type predict_word(term_request_type rq);
      term_word_type w;
      w.cell_entry = '0;
      if (rq.op == OP_PUT) begin
         if (rq.ch == NEWLINE_CHAR) begin
            shadow_row++;
            shadow_column = 0;
         end else begin
            screen_shadow[shadow_row * COLUMNS + shadow_column] = {shadow_color, rq.ch};
            shadow_column++;
         end
         if (shadow_column >= COLUMNS) begin
            shadow_column = 0;
            shadow_row++;
         end
         if (shadow_row >= ROWS) begin
            scroll_shadow();
            shadow_row = ROWS - 1;
         end
      end else if (rq.cell_index < CELL_COUNT) begin
         w.cell_entry = screen_shadow[rq.cell_index];
      end
      w.cursor_row    = OUT_ROW_W'(shadow_row);
      w.cursor_column = OUT_COL_W'(shadow_column);
      return w;
   endfunction

   function automatic term_request_type make_request(op_type op, logic [CHAR_W-1:0] ch,
                                                     logic [INDEX_W-1:0] idx, bit drain);
      term_request_type rq;
      rq.op          = op;
      rq.ch          = ch;
      rq.cell_index  = idx;
      rq.drain_first = drain;
      return rq;
   endfunction

   function automatic term_request_type random_put(logic [CHAR_W-1:0] ch);
      return make_request(OP_PUT, ch, INDEX_W'($urandom_range(0, 2047)),
                          $urandom_range(0, 99) == 0);
   endfunction

   // Reads lean toward the bottom rows, where recent text lands after scrolling.
   function automatic term_request_type random_read();
      int r;
      int idx;
      r = $urandom_range(0, 99);
      if (r < 45)
         idx = $urandom_range((ROWS - 6) * COLUMNS, CELL_COUNT - 1);
      else if (r < 85)
         idx = $urandom_range(0, CELL_COUNT - 1);
      else
         idx = $urandom_range(CELL_COUNT, 2047);
      return make_request(OP_READ, CHAR_W'($urandom_range(0, 255)), INDEX_W'(idx),
                          $urandom_range(0, 99) == 0);
   endfunction

   // Random phase: lines of text of varied length, mostly newline terminated,
   // with reads mixed in and occasional bursts of reads.
   task automatic queue_random_phase(int count);
      int queued;
      int len;
      int r;
      queued = 0;
      while (queued < count) begin
         if ($urandom_range(0, 99) < 70) begin
            r = $urandom_range(0, 99);
            if (r < 75)
               len = $urandom_range(0, 12);
            else if (r < 90)
               len = $urandom_range(COLUMNS - 4, COLUMNS + 4);
            else
               len = 2 * COLUMNS;
            for (int i = 0; i < len; i++) begin
               pending_requests.push_back(random_put(CHAR_W'($urandom_range(0, 255))));
               queued++;
               if ($urandom_range(0, 99) < 20) begin
                  pending_requests.push_back(random_read());
                  queued++;
               end
            end
            if ($urandom_range(0, 99) < 75) begin
               pending_requests.push_back(random_put(NEWLINE_CHAR));
               queued++;
            end
         end else begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++) begin
               pending_requests.push_back(random_read());
               queued++;
            end
         end
      end
   endtask

   // Waits until the driver is idle and every predicted word has arrived.
   task automatic wait_drained();
      do
         @(posedge clock);
      while (pending_requests.size() != 0 || req_bus.valid || expected_words.size() != 0);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_read_check(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] want);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      if (csr_prdata !== want)
         report_mismatch("text_color readback", longint'(want), longint'(csr_prdata));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Request driver: records each accepted word in the shadow and presents the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            expected_words.push_back(predict_word(current_request));
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_requests.size() != 0 && !idle_now() &&
                (!pending_requests[0].drain_first || expected_words.size() == 0)) begin
               current_request    = pending_requests.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.op         <= current_request.op;
               req_bus.ch         <= current_request.ch;
               req_bus.cell_index <= current_request.cell_index;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: compares each accepted word with the oldest prediction.
   always @(posedge clock) begin
      term_word_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word, cell_entry", 0,
                               longint'(rsp_bus.cell_entry));
            end else begin
               want = expected_words.pop_front();
               if (rsp_bus.cell_entry !== want.cell_entry)
                  report_mismatch("cell_entry", longint'(want.cell_entry),
                                  longint'(rsp_bus.cell_entry));
               if (rsp_bus.cursor_row !== want.cursor_row)
                  report_mismatch("cursor_row", longint'(want.cursor_row),
                                  longint'(rsp_bus.cursor_row));
               if (rsp_bus.cursor_column !== want.cursor_column)
                  report_mismatch("cursor_column", longint'(want.cursor_column),
                                  longint'(rsp_bus.cursor_column));
            end
         end
         rsp_bus.ready <= !idle_now();
      end
   end

   // Watchdog on cycles with no transfer on any port.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          csr_psel) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Main sequence: reset, directed words, then random phases under several colors.
   initial begin
      logic [ATTR_W-1:0] phase_colors [PHASE_COUNT];
      logic [ATTR_W-1:0] color;

      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.op         = OP_PUT;
      req_bus.ch         = '0;
      req_bus.cell_index = '0;
      rsp_bus.ready      = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      for (int i = 0; i < CELL_COUNT; i++)
         screen_shadow[i] = BLANK_CELL;
      shadow_row    = 0;
      shadow_column = 0;
      shadow_color  = TEXT_COLOR_RESET;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // The reset color reads back, and a write to an unmapped address is ignored.
      csr_read_check(ADDR_TEXT_COLOR, CSR_DATA_W'(TEXT_COLOR_RESET));
      csr_write(ADDR_UNMAPPED, $urandom());
      csr_read_check(ADDR_TEXT_COLOR, CSR_DATA_W'(TEXT_COLOR_RESET));

      // Directed words: blank buffer, reads past the end, character extremes, newlines.
      pending_requests.push_back(make_request(OP_READ, 8'hFF, 11'd0, 1'b0));
      pending_requests.push_back(make_request(OP_READ, 8'h00, 11'd1999, 1'b0));
      pending_requests.push_back(make_request(OP_READ, 8'h00, 11'd2000, 1'b0));
      pending_requests.push_back(make_request(OP_READ, 8'hFF, 11'd2047, 1'b0));
      pending_requests.push_back(make_request(OP_PUT, 8'h00, 11'd2047, 1'b0));
      pending_requests.push_back(make_request(OP_PUT, 8'hFF, 11'd0, 1'b0));
      pending_requests.push_back(make_request(OP_PUT, SPACE_CHAR, 11'd0, 1'b0));
      pending_requests.push_back(make_request(OP_PUT, 8'h41, 11'd0, 1'b0));
      for (int i = 0; i < 4; i++)
         pending_requests.push_back(make_request(OP_READ, 8'h00, INDEX_W'(i), 1'b0));
      pending_requests.push_back(make_request(OP_PUT, NEWLINE_CHAR, 11'd0, 1'b0));
      pending_requests.push_back(make_request(OP_PUT, NEWLINE_CHAR, 11'd0, 1'b0));
      pending_requests.push_back(make_request(OP_READ, 8'h00, 11'd80, 1'b0));
      pending_requests.push_back(make_request(OP_PUT, 8'h7F, 11'd0, 1'b0));
      pending_requests.push_back(make_request(OP_PUT, 8'h80, 11'd0, 1'b0));
      pending_requests.push_back(make_request(OP_READ, 8'h00, 11'd160, 1'b0));
      pending_requests.push_back(make_request(OP_READ, 8'h00, 11'd161, 1'b1));
      pending_requests.push_back(make_request(OP_READ, 8'h00, 11'd162, 1'b0));

      // Attribute settings for the random phases, extremes included.
      phase_colors[0] = 8'h00;
      phase_colors[1] = 8'hFF;
      phase_colors[2] = 8'h1E;
      phase_colors[3] = ATTR_W'($urandom_range(0, 255));
      phase_colors[4] = 8'hF0;
      phase_colors[5] = 8'h0F;
      phase_colors[6] = ATTR_W'($urandom_range(0, 255));
      phase_colors[7] = TEXT_COLOR_RESET;

      for (int p = 0; p < PHASE_COUNT; p++) begin
         // The sender holds off until everything is back and any scroll has finished.
         wait_drained();
         repeat (SETTLE_CYCLES) @(posedge clock);
         color = phase_colors[p];
         csr_write(ADDR_TEXT_COLOR, {(CSR_DATA_W - ATTR_W)'($urandom()), color});
         shadow_color = color;
         csr_read_check(ADDR_TEXT_COLOR, CSR_DATA_W'(color));
         steady = (p == STEADY_PHASE);
         queue_random_phase(PHASE_REQUESTS);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/tmtw_pkg.sv
src/tmtw_if.sv
src/tmtw_ram.sv
src/text_mode_terminal_writer.sv
src/tmtw_checker.sv
tb/sv/text_mode_terminal_writer_test.sv
